[rtl/swr_pkg.sv]
`default_nettype none

package swr_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned WidthW = 4;
  localparam int unsigned CountW = 4;
  localparam int unsigned AccW   = 15;
  localparam int unsigned CfgAddrW = 1;

  typedef logic [CfgAddrW-1:0] cfg_addr_t;

  localparam cfg_addr_t CfgInBits  = 1'b0;
  localparam cfg_addr_t CfgOutBits = 1'b1;

  localparam logic [WidthW-1:0] InBitsReset  = 4'd8;
  localparam logic [WidthW-1:0] OutBitsReset = 4'd1;

  // Register value clamped to 1..8.
  function automatic logic [CountW-1:0] eff_width(input logic [WidthW-1:0] w);
    logic [CountW-1:0] r;
    r = w;
    if (w == '0) begin
      r = 4'd1;
    end else if (w > 4'd8) begin
      r = 4'd8;
    end
    return r;
  endfunction

  // Ones in the low n bits.
  function automatic logic [AccW-1:0] low_mask(input logic [CountW-1:0] n);
    logic [AccW:0] m;
    m = ({{AccW{1'b0}}, 1'b1} << n) - {{AccW{1'b0}}, 1'b1};
    return m[AccW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/symbol_width_repacker.sv]
`default_nettype none

// MSB-first gearbox: regroups symbols of in_bits bits (low bits of sym_in_i) into
// symbols of out_bits bits. An accepted beat is merged into a 15-bit accumulator;
// one full output symbol is emitted per cycle from its top unless the output is
// stalled, and a beat with frame_end_i set flushes any partial symbol left-aligned
// and zero-padded. A beat causes n output symbols (up to 8
// with out_bits = 1): the next beat is taken in the cycle the previous beat's
// last symbol moves into the output register. A config write clears held bits
// and must happen only while the block is idle.

module symbol_width_repacker (
  input  wire                       clk_i,
  input  wire                       rst_ni,

  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire swr_pkg::cfg_addr_t   cfg_addr_i,
  input  wire [swr_pkg::WidthW-1:0] cfg_data_i,

  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire [swr_pkg::SymW-1:0]   sym_in_i,
  input  wire                       frame_end_i,

  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [swr_pkg::SymW-1:0]  sym_out_o,
  output logic                      run_last_o,
  output logic                      frame_last_o
);
  import swr_pkg::*;

  logic [WidthW-1:0] in_bits_q, out_bits_q;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              fend_q, fend_d;

  logic              out_valid_q;
  logic [SymW-1:0]   sym_out_q;
  logic              run_last_q, frame_last_q;

  logic [CountW-1:0] ib, ob, cnt_after;
  logic              emit_full, emit_flush, emit, out_free, emit_fire;
  logic              last_after, in_fire, cfg_fire;
  logic [AccW-1:0]   shr_word, shl_word, acc_kept, sym_in_ext, ob_mask;
  logic [SymW-1:0]   emit_sym;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  assign ib = eff_width(in_bits_q);
  assign ob = eff_width(out_bits_q);

  assign emit_full  = cnt_q >= ob;
  assign emit_flush = fend_q && (cnt_q != '0) && (cnt_q < ob);
  assign emit       = emit_full || emit_flush;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = emit && out_free;

  assign shr_word = acc_q >> (cnt_q - ob);
  assign shl_word = acc_q << (ob - cnt_q);
  assign ob_mask  = low_mask(ob);

  always_comb begin
    emit_sym = emit_full ? shr_word[SymW-1:0] : shl_word[SymW-1:0];
    emit_sym = emit_sym & ob_mask[SymW-1:0];
  end

  always_comb begin
    cnt_after = cnt_q;
    if (emit_fire) begin
      cnt_after = emit_full ? (cnt_q - ob) : '0;
    end
  end

  // No further symbol owed by the beat in flight.
  assign last_after = (cnt_after < ob) && !(fend_q && (cnt_after != '0));

  assign in_stall_o = !last_after || cfg_valid_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign acc_kept   = acc_q & low_mask(cnt_after);
  assign sym_in_ext = {{(AccW-SymW){1'b0}}, sym_in_i} & low_mask(ib);

  always_comb begin
    acc_d  = acc_kept;
    cnt_d  = cnt_after;
    fend_d = fend_q;
    if (cfg_fire) begin
      acc_d  = '0;
      cnt_d  = '0;
      fend_d = 1'b0;
    end else if (in_fire) begin
      acc_d  = (acc_kept << ib) | sym_in_ext;
      cnt_d  = cnt_after + ib;
      fend_d = frame_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bits_q  <= InBitsReset;
      out_bits_q <= OutBitsReset;
    end else if (cfg_fire) begin
      unique case (cfg_addr_i)
        CfgInBits:  in_bits_q  <= cfg_data_i;
        CfgOutBits: out_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      fend_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      fend_q <= fend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      sym_out_q    <= emit_sym;
      run_last_q   <= last_after;
      frame_last_q <= last_after && fend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sym_out_o    = sym_out_q;
  assign run_last_o   = run_last_q;
  assign frame_last_o = frame_last_q;

  a_merge_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (cnt_after < ob) && (emit_fire || !emit))
    else $error("beat merged while symbols still owed");

  a_frame_last_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!frame_last_o || run_last_o))
    else $error("frame_last without run_last");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> (cnt_q == '0) && !fend_q)
    else $error("config write left held bits");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !emit |=> !out_valid_o)
    else $error("output beat repeated");

endmodule

`default_nettype wire
